[hdl/es2utc_pkg.sv]
`default_nettype none

package es2utc_pkg;

  // Field widths.
  localparam int unsigned SECS_W = 40;
  localparam int unsigned DAY_W  = 24;
  localparam int unsigned TOD_W  = 17;

  // Register stages from an accepted transaction to the output register.
  localparam int unsigned LATENCY = 13;

  // Stages the time-of-day path holds its result for, so that it lines up with the date path.
  localparam int unsigned CLOCK_TAIL = 5;

  // Stages the weekday waits before joining the date result.
  localparam int unsigned WDAY_TAIL = 7;

  // 86400 * 6362915: a whole number of days that lifts every input above zero.
  localparam logic [40:0] SECS_BIAS = 41'd549755856000;

  // 86400 = 675 * 128, so the day split is a shift followed by a division by 675.
  localparam logic [9:0] DIV675 = 10'd675;

  // Reciprocals are ceil(2^S / d) with S = N + ceil(log2 d), exact for N-bit dividends.
  localparam int unsigned RCP_HI_SH = 27;
  localparam logic [17:0] RCP_HI =
    18'(((64'd1 << RCP_HI_SH) + 64'd674) / 64'd675);

  localparam int unsigned RCP_LO_SH = 37;
  localparam logic [27:0] RCP_LO =
    28'(((64'd1 << RCP_LO_SH) + 64'd674) / 64'd675);

  // Day count offset: 719468 + 44 * 146097 - 6362915.
  localparam logic [23:0] DAY_BIAS = 24'd784821;

  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam int unsigned RCP_ERA_SH = 42;
  localparam logic [24:0] RCP_ERA =
    25'(((64'd1 << RCP_ERA_SH) + 64'd146096) / 64'd146097);

  localparam logic [5:0] SIXTY = 6'd60;
  localparam int unsigned RCP_60_SH = 23;
  localparam logic [17:0] RCP_60 = 18'(((64'd1 << RCP_60_SH) + 64'd59) / 64'd60);
  localparam int unsigned RCP_60M_SH = 17;
  localparam logic [11:0] RCP_60M = 12'(((64'd1 << RCP_60M_SH) + 64'd59) / 64'd60);

  localparam int unsigned RCP_1460_SH = 29;
  localparam logic [18:0] RCP_1460 =
    19'(((64'd1 << RCP_1460_SH) + 64'd1459) / 64'd1460);

  localparam int unsigned RCP_365_SH = 27;
  localparam logic [18:0] RCP_365 =
    19'(((64'd1 << RCP_365_SH) + 64'd364) / 64'd365);

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [17:0] CENT_DAYS_1   = 18'd36524;
  localparam logic [17:0] CENT_DAYS_2   = 18'd73048;
  localparam logic [17:0] CENT_DAYS_3   = 18'd109572;
  localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;

  // Year offset: 1900 plus the 44 eras of the day count offset, 1900 + 44 * 400.
  localparam logic [16:0] YEAR_BIAS    = 17'd19500;
  localparam logic [8:0]  YEARS_PER_ERA = 9'd400;

  typedef struct packed {
    logic [DAY_W-1:0] day_num;
    logic [TOD_W-1:0] tod;
  } split_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  typedef struct packed {
    logic [4:0]        month_day;
    logic [3:0]        month;
    logic signed [15:0] year_since_1900;
    logic [2:0]        weekday;
    logic [8:0]        year_day;
  } date_t;

  // First day of each month in a year that starts on March 1.
  function automatic logic [8:0] march_start(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // First day of each civil month, January being month 0.
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && mon >= 4'd2) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

[hdl/epoch_seconds_to_utc_calendar.sv]
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_ready_o    epoch_seconds_i (40-bit signed)
// output    out        out_valid_o / out_ready_i  second_o, minute_o, hour_o, month_day_o,
//                                                 month_o, year_since_1900_o, weekday_o,
//                                                 year_day_o
//
// One transaction is taken every clock cycle unless the output stalls. The depth of the
// pipeline is set by the constant divisions (by 86400, 146097, 1460 and 365) on the date path,
// each a reciprocal multiplication and a correcting subtraction over a few register stages.
// Reset clears only the valid bits of the stages; the data registers are left as they are.
// When the output holds a result that is not taken, the whole pipeline holds still, empty
// stages included, so nothing is lost or repeated and the input waits until it moves again.
module epoch_seconds_to_utc_calendar (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [es2utc_pkg::SECS_W-1:0] epoch_seconds_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [5:0]                         second_o,
  output logic [5:0]                         minute_o,
  output logic [4:0]                         hour_o,
  output logic [4:0]                         month_day_o,
  output logic [3:0]                         month_o,
  output logic signed [15:0]                 year_since_1900_o,
  output logic [2:0]                         weekday_o,
  output logic [8:0]                         year_day_o
);

  logic                               en;
  logic [es2utc_pkg::LATENCY-1:0]     vld_d, vld_q;
  es2utc_pkg::split_t                 split;
  es2utc_pkg::hms_t                   hms;
  es2utc_pkg::date_t                  date;

  // Every stage advances together unless the output register holds a result that
  // the receiver is not taking in this cycle.
  assign en         = !vld_q[es2utc_pkg::LATENCY-1] || out_ready_i;
  assign in_ready_o = en;

  // The valid bit of a new transaction enters with its data and travels beside it.
  assign vld_d = {vld_q[es2utc_pkg::LATENCY-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // Stages one to five: floor division of the seconds by 86400.
  es2utc_split u_split (
    .clk_i           (clk_i),
    .en_i            (en),
    .epoch_seconds_i (epoch_seconds_i),
    .split_o         (split)
  );

  // Stages six to thirteen: time of day, held back to meet the date path.
  es2utc_clock u_clock (
    .clk_i (clk_i),
    .en_i  (en),
    .tod_i (split.tod),
    .hms_o (hms)
  );

  // Stages six to thirteen: era, year of era, month, and the civil date.
  es2utc_date u_date (
    .clk_i     (clk_i),
    .en_i      (en),
    .day_num_i (split.day_num),
    .date_o    (date)
  );

  assign out_valid_o       = vld_q[es2utc_pkg::LATENCY-1];
  assign second_o          = hms.second;
  assign minute_o          = hms.minute;
  assign hour_o            = hms.hour;
  assign month_day_o       = date.month_day;
  assign month_o           = date.month;
  assign year_since_1900_o = date.year_since_1900;
  assign weekday_o         = date.weekday;
  assign year_day_o        = date.year_day;

endmodule

`default_nettype wire

[hdl/es2utc_split.sv]
`default_nettype none

// Splits signed seconds into a biased day number and the seconds within the day.
module es2utc_split (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic [es2utc_pkg::SECS_W-1:0]   epoch_seconds_i,
  output es2utc_pkg::split_t                   split_o
);

  logic [40:0] biased;
  logic [16:0] hi_q, lo_q, hi2_q, lo2_q, lo3_q;
  logic [6:0]  sub_q, sub2_q, sub3_q, sub4_q;
  logic [34:0] prod_hi_d, prod_hi_q;
  logic [7:0]  qh_d, qh_q, qh4_q;
  logic [16:0] rh_full;
  logic [9:0]  rh_d, rh_q;
  logic [26:0] v_d, v_q;
  logic [54:0] prod_lo_d, prod_lo_q;
  logic [16:0] ql;
  logic [26:0] rl_full;
  es2utc_pkg::split_t split_d, split_q;

  assign biased = {epoch_seconds_i[es2utc_pkg::SECS_W-1], epoch_seconds_i}
                + es2utc_pkg::SECS_BIAS;

  // Upper part of the seconds divided by 675 first, then the remainder with the lower part.
  assign prod_hi_d = 35'(hi_q) * 35'(es2utc_pkg::RCP_HI);
  assign qh_d      = prod_hi_q[34:27];
  assign rh_full   = hi2_q - 17'(qh_d) * 17'(es2utc_pkg::DIV675);
  assign rh_d      = rh_full[9:0];
  assign v_d       = {rh_q, lo3_q};
  assign prod_lo_d = 55'(v_d) * 55'(es2utc_pkg::RCP_LO);
  assign ql        = prod_lo_q[53:37];
  assign rl_full   = v_q - 27'(ql) * 27'(es2utc_pkg::DIV675);

  always_comb begin
    split_d.day_num = {qh4_q[6:0], ql};
    split_d.tod     = {rl_full[9:0], sub4_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q      <= biased[40:24];
      lo_q      <= biased[23:7];
      sub_q     <= biased[6:0];
      prod_hi_q <= prod_hi_d;
      hi2_q     <= hi_q;
      lo2_q     <= lo_q;
      sub2_q    <= sub_q;
      qh_q      <= qh_d;
      rh_q      <= rh_d;
      lo3_q     <= lo2_q;
      sub3_q    <= sub2_q;
      prod_lo_q <= prod_lo_d;
      v_q       <= v_d;
      qh4_q     <= qh_q;
      sub4_q    <= sub3_q;
      split_q   <= split_d;
    end
  end

  assign split_o = split_q;

endmodule

`default_nettype wire

[hdl/es2utc_clock.sv]
`default_nettype none

// Breaks the seconds within a day into hour, minute and second.
module es2utc_clock (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [es2utc_pkg::TOD_W-1:0]  tod_i,
  output es2utc_pkg::hms_t                   hms_o
);

  logic [34:0] prod_m_d, prod_m_q;
  logic [16:0] tod_q;
  logic [10:0] tm_d, tm_q, tm2_q;
  logic [16:0] sec_full;
  logic [5:0]  sec_d, sec_q, sec2_q;
  logic [22:0] prod_h_d, prod_h_q;
  logic [4:0]  hour;
  logic [10:0] min_full;
  es2utc_pkg::hms_t hms_d;
  es2utc_pkg::hms_t tail_q [es2utc_pkg::CLOCK_TAIL];

  assign prod_m_d = 35'(tod_i) * 35'(es2utc_pkg::RCP_60);
  assign tm_d     = prod_m_q[33:23];
  assign sec_full = tod_q - 17'(tm_d) * 17'(es2utc_pkg::SIXTY);
  assign sec_d    = sec_full[5:0];
  assign prod_h_d = 23'(tm_q) * 23'(es2utc_pkg::RCP_60M);
  assign hour     = prod_h_q[21:17];
  assign min_full = tm2_q - 11'(hour) * 11'(es2utc_pkg::SIXTY);

  always_comb begin
    hms_d.hour   = hour;
    hms_d.minute = min_full[5:0];
    hms_d.second = sec2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_m_q  <= prod_m_d;
      tod_q     <= tod_i;
      tm_q      <= tm_d;
      sec_q     <= sec_d;
      prod_h_q  <= prod_h_d;
      tm2_q     <= tm_q;
      sec2_q    <= sec_q;
      tail_q[0] <= hms_d;
      for (int i = 1; i < es2utc_pkg::CLOCK_TAIL; i++) begin
        tail_q[i] <= tail_q[i-1];
      end
    end
  end

  assign hms_o = tail_q[es2utc_pkg::CLOCK_TAIL-1];

endmodule

`default_nettype wire

[hdl/es2utc_date.sv]
`default_nettype none

// Turns the biased day number into a Gregorian date, weekday and day of year.
module es2utc_date (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [es2utc_pkg::DAY_W-1:0]  day_num_i,
  output es2utc_pkg::date_t                  date_o
);

  // Weekday by folding base-8 digits, since 8 leaves 1 modulo 7.
  logic [26:0] wsum_in;
  logic [5:0]  wsum;
  logic [3:0]  wfold;
  logic [2:0]  wday_d;
  logic [2:0]  wday_q [es2utc_pkg::WDAY_TAIL];

  logic [23:0] z_d, z_q;
  logic [48:0] prod_era_d, prod_era_q;
  logic [6:0]  era_d, era7_q, era8_q, era9_q, era10_q, era11_q, era12_q;
  logic [23:0] doe_full;
  logic [17:0] doe_d, doe7_q, doe8_q, doe9_q, doe10_q;
  logic [36:0] prod_c_d, prod_c_q;
  logic [2:0]  cent_d, cent_q;
  logic        last_d, last_q;
  logic [17:0] t_d, t_q;
  logic [36:0] prod_y_d, prod_y_q;
  logic [8:0]  yoe_d, yoe11_q;
  logic [1:0]  yc;
  logic [18:0] base;
  logic [18:0] doy_full;
  logic [8:0]  doy_d, doy_q;
  logic [3:0]  mp;
  logic [8:0]  mday_full;
  logic [3:0]  mon_d, mon_q;
  logic [4:0]  mday_d, mday_q;
  logic [8:0]  yy_d, yy_q;
  logic        leap;
  logic [16:0] year_full;
  es2utc_pkg::date_t date_d, date_q;

  always_comb begin
    wsum_in = 27'(day_num_i) + 27'd5;
    wsum    = 6'd0;
    for (int k = 0; k < 9; k++) begin
      wsum = wsum + 6'(wsum_in[3*k +: 3]);
    end
    wfold = 4'(wsum[5:3]) + 4'(wsum[2:0]);
    if (wfold >= 4'd14) begin
      wday_d = 3'(wfold - 4'd14);
    end else if (wfold >= 4'd7) begin
      wday_d = 3'(wfold - 4'd7);
    end else begin
      wday_d = wfold[2:0];
    end
  end

  // Era and day of era.
  assign z_d        = day_num_i + es2utc_pkg::DAY_BIAS;
  assign prod_era_d = 49'(z_d) * 49'(es2utc_pkg::RCP_ERA);
  assign era_d      = prod_era_q[48:42];
  assign doe_full   = z_q - 24'(era_d) * 24'(es2utc_pkg::DAYS_PER_ERA);
  assign doe_d      = doe_full[17:0];

  // Year of era.
  assign prod_c_d = 37'(doe7_q) * 37'(es2utc_pkg::RCP_1460);
  assign cent_d   = 3'(doe7_q >= es2utc_pkg::CENT_DAYS_1) + 3'(doe7_q >= es2utc_pkg::CENT_DAYS_2)
                  + 3'(doe7_q >= es2utc_pkg::CENT_DAYS_3) + 3'(doe7_q >= es2utc_pkg::ERA_LAST_DAY);
  assign last_d   = (doe7_q == es2utc_pkg::ERA_LAST_DAY);
  assign t_d      = doe8_q - 18'(prod_c_q[36:29]) + 18'(cent_q) - 18'(last_q);
  assign prod_y_d = 37'(t_q) * 37'(es2utc_pkg::RCP_365);
  assign yoe_d    = prod_y_q[35:27];

  always_comb begin
    yc       = 2'(yoe_d >= 9'd100) + 2'(yoe_d >= 9'd200) + 2'(yoe_d >= 9'd300);
    base     = 19'(yoe_d) * 19'(es2utc_pkg::DAYS_PER_YEAR) + 19'(yoe_d[8:2]) - 19'(yc);
    doy_full = 19'(doe10_q) - base;
    doy_d    = doy_full[8:0];
  end

  // Month within the March-based year, then the civil month and year.
  always_comb begin
    mp = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy_q >= es2utc_pkg::march_start(4'(k))) begin
        mp = mp + 4'd1;
      end
    end
    mday_full = doy_q - es2utc_pkg::march_start(mp) + 9'd1;
    mday_d    = mday_full[4:0];
    if (mp < 4'd10) begin
      mon_d = mp + 4'd2;
      yy_d  = yoe11_q;
    end else begin
      mon_d = mp - 4'd10;
      yy_d  = yoe11_q + 9'd1;
    end
  end

  always_comb begin
    leap = (yy_q[1:0] == 2'b00) && !(yy_q inside {9'd100, 9'd200, 9'd300});
    year_full = 17'(era12_q) * 17'(es2utc_pkg::YEARS_PER_ERA) + 17'(yy_q)
              - es2utc_pkg::YEAR_BIAS;
    date_d.month_day       = mday_q;
    date_d.month           = mon_q;
    date_d.year_since_1900 = year_full[15:0];
    date_d.weekday         = wday_q[es2utc_pkg::WDAY_TAIL-1];
    date_d.year_day        = es2utc_pkg::month_start(leap, mon_q) + 9'(mday_q) - 9'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wday_q[0] <= wday_d;
      for (int i = 1; i < es2utc_pkg::WDAY_TAIL; i++) begin
        wday_q[i] <= wday_q[i-1];
      end
      z_q        <= z_d;
      prod_era_q <= prod_era_d;
      era7_q     <= era_d;
      doe7_q     <= doe_d;
      prod_c_q   <= prod_c_d;
      cent_q     <= cent_d;
      last_q     <= last_d;
      doe8_q     <= doe7_q;
      era8_q     <= era7_q;
      t_q        <= t_d;
      doe9_q     <= doe8_q;
      era9_q     <= era8_q;
      prod_y_q   <= prod_y_d;
      doe10_q    <= doe9_q;
      era10_q    <= era9_q;
      yoe11_q    <= yoe_d;
      doy_q      <= doy_d;
      era11_q    <= era10_q;
      mon_q      <= mon_d;
      mday_q     <= mday_d;
      yy_q       <= yy_d;
      era12_q    <= era11_q;
      date_q     <= date_d;
    end
  end

  assign date_o = date_q;

endmodule

`default_nettype wire
